>>> rtl/core/gfpsq_pkg.sv
// Shared types, codes and constants for the GF(p^2) arithmetic unit.
package gfpsq_pkg;

    localparam int DEF_PRIME = 139;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_ORD = 3'd5;

    // lane operand selection
    typedef enum logic [2:0] {
        MS_LOAD,
        MS_A_B,
        MS_ACC_SQ,
        MS_SQ_SQ,
        MS_A_ACC
    } mul_sel_t;

    // lane result write-back target
    typedef enum logic [1:0] {
        WB_NONE,
        WB_AB,
        WB_ACC,
        WB_SQ
    } wb_t;

    typedef enum logic [1:0] {
        INIT_NONE,
        INIT_POW_A,
        INIT_POW_B,
        INIT_ORD
    } init_t;

    typedef enum logic [2:0] {
        OS_ACC,
        OS_ADD,
        OS_SUB,
        OS_ZERO,
        OS_COUNT
    } out_src_t;

    typedef struct packed {
        logic     accept;
        logic     mul_start;
        mul_sel_t mul_sel;
        wb_t      wb;
        init_t    init;
        logic     e_shift;
        logic     cnt_inc;
        logic     out_load;
        out_src_t out_src;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       lanes_done;
        logic       e_zero;
        logic       e_lsb;
        logic       a_zero;
        logic       acc_one;
        logic       cnt_at_limit;
        logic       slot_free;
    } dp_stat_t;

endpackage

>>> rtl/core/gfpsq_modmul.sv
// Bit-serial modular multiplier lane: prod = x * y mod PRIME, MSB of x first.
module gfpsq_modmul
    import gfpsq_pkg::*;
#(
    parameter int PRIME = DEF_PRIME
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [((($clog2(PRIME)) > 8) ? $clog2(PRIME) : 8)-1:0] x,
    input  logic [$clog2(PRIME)-1:0]    y,
    output logic                        done,
    output logic [$clog2(PRIME)-1:0]    prod
);

    localparam int EW = $clog2(PRIME);
    localparam int SW = (EW > 8) ? EW : 8;
    localparam int KW = $clog2(SW + 1);
    localparam logic [EW+1:0] P1 = (EW+2)'(PRIME);
    localparam logic [EW+1:0] P2 = (EW+2)'(2 * PRIME);

    logic [SW-1:0] x_reg;
    logic [EW-1:0] y_reg;
    logic [EW-1:0] r_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;
    logic [EW+1:0] t;
    logic [EW+1:0] t_red;

    always_comb
    begin
        t = {1'b0, r_reg, 1'b0} + (x_reg[SW-1] ? {2'b00, y_reg} : '0);
        if (t >= P2)
        begin
            t_red = t - P2;
        end
        else if (t >= P1)
        begin
            t_red = t - P1;
        end
        else
        begin
            t_red = t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= KW'(SW);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            r_reg <= '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            x_reg <= {x_reg[SW-2:0], 1'b0};
            r_reg <= t_red[EW-1:0];
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign prod = r_reg;

endmodule

>>> rtl/core/gfpsq_datapath.sv
// Datapath: operand, accumulator and square registers, four multiplier lanes, output word.
module gfpsq_datapath
    import gfpsq_pkg::*;
#(
    parameter int PRIME = DEF_PRIME
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [2:0]  operation,
    input  logic [7:0]  first_re,
    input  logic [7:0]  first_im,
    input  logic [7:0]  second_re,
    input  logic [7:0]  second_im,
    input  logic [31:0] exponent,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  result_re,
    output logic [7:0]  result_im,
    output logic [14:0] element_order
);

    localparam int EW = $clog2(PRIME);
    localparam int SW = (EW > 8) ? EW : 8;
    localparam int CW = $clog2(PRIME * PRIME);
    localparam int OW = (CW > 15) ? CW : 15;
    localparam logic [EW:0]   PE = (EW+1)'(PRIME);
    localparam logic [31:0]   DIV_EXP = 32'(PRIME * PRIME - 2);
    localparam logic [CW-1:0] ORD_LIMIT = CW'(PRIME * PRIME - 1);
    localparam logic [EW-1:0] ONE = EW'(1);

    logic [2:0]    op_reg;
    logic [7:0]    raw_reg [4];
    logic [31:0]   e_reg;
    logic [EW-1:0] a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    logic [EW-1:0] acc_re_reg, acc_im_reg, sq_re_reg, sq_im_reg;
    logic [CW-1:0] cnt_reg;
    logic          out_valid_reg;
    logic [7:0]    out_re_reg, out_im_reg;
    logic [14:0]   out_ord_reg;

    logic [EW-1:0] u_re, u_im, v_re, v_im;
    logic [SW-1:0] lx [4];
    logic [EW-1:0] ly [4];
    logic [EW-1:0] lp [4];
    logic [3:0]    ldone;
    logic [EW:0]   mre_s, mim_s, add_re_s, add_im_s, sub_re_s, sub_im_s;
    logic [EW-1:0] mre, mim, add_re, add_im, sub_re, sub_im;
    logic [EW-1:0] sel_re, sel_im;
    logic [SW-1:0] ext_re, ext_im;
    logic [OW-1:0] ext_cnt;

    function automatic logic [EW-1:0] red1(input logic [EW:0] s);
        logic [EW:0] d;
        d = (s >= PE) ? s - PE : s;
        return d[EW-1:0];
    endfunction

    always_comb
    begin
        u_re = a_re_reg;
        u_im = a_im_reg;
        v_re = b_re_reg;
        v_im = b_im_reg;
        case (cmd.mul_sel)
            MS_ACC_SQ:
            begin
                u_re = acc_re_reg; u_im = acc_im_reg;
                v_re = sq_re_reg;  v_im = sq_im_reg;
            end
            MS_SQ_SQ:
            begin
                u_re = sq_re_reg; u_im = sq_im_reg;
                v_re = sq_re_reg; v_im = sq_im_reg;
            end
            MS_A_ACC:
            begin
                v_re = acc_re_reg; v_im = acc_im_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.mul_sel == MS_LOAD)
        begin
            for (int i = 0; i < 4; i++)
            begin
                lx[i] = SW'(raw_reg[i]);
                ly[i] = ONE;
            end
        end
        else
        begin
            lx[0] = SW'(u_re); ly[0] = v_re;
            lx[1] = SW'(u_im); ly[1] = v_im;
            lx[2] = SW'(u_im); ly[2] = v_re;
            lx[3] = SW'(u_re); ly[3] = v_im;
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        gfpsq_modmul #(.PRIME(PRIME)) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (cmd.mul_start),
            .x     (lx[g]),
            .y     (ly[g]),
            .done  (ldone[g]),
            .prod  (lp[g])
        );
    end

    // re = ac - bd, im = ad + bc
    always_comb
    begin
        mre_s    = {1'b0, lp[0]} + PE - {1'b0, lp[1]};
        mim_s    = {1'b0, lp[2]} + {1'b0, lp[3]};
        add_re_s = {1'b0, a_re_reg} + {1'b0, b_re_reg};
        add_im_s = {1'b0, a_im_reg} + {1'b0, b_im_reg};
        sub_re_s = {1'b0, a_re_reg} + PE - {1'b0, b_re_reg};
        sub_im_s = {1'b0, a_im_reg} + PE - {1'b0, b_im_reg};
        mre      = red1(mre_s);
        mim      = red1(mim_s);
        add_re   = red1(add_re_s);
        add_im   = red1(add_im_s);
        sub_re   = red1(sub_re_s);
        sub_im   = red1(sub_im_s);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= operation;
            raw_reg[0] <= first_re;
            raw_reg[1] <= first_im;
            raw_reg[2] <= second_re;
            raw_reg[3] <= second_im;
            e_reg      <= exponent;
        end
        case (cmd.wb)
            WB_AB:
            begin
                a_re_reg <= lp[0]; a_im_reg <= lp[1];
                b_re_reg <= lp[2]; b_im_reg <= lp[3];
            end
            WB_ACC:
            begin
                acc_re_reg <= mre; acc_im_reg <= mim;
            end
            WB_SQ:
            begin
                sq_re_reg <= mre; sq_im_reg <= mim;
            end
            default:
            begin
            end
        endcase
        case (cmd.init)
            INIT_POW_A:
            begin
                acc_re_reg <= ONE; acc_im_reg <= '0;
                sq_re_reg  <= a_re_reg; sq_im_reg <= a_im_reg;
            end
            INIT_POW_B:
            begin
                acc_re_reg <= ONE; acc_im_reg <= '0;
                sq_re_reg  <= b_re_reg; sq_im_reg <= b_im_reg;
                e_reg      <= DIV_EXP;
            end
            INIT_ORD:
            begin
                acc_re_reg <= a_re_reg; acc_im_reg <= a_im_reg;
                cnt_reg    <= CW'(1);
            end
            default:
            begin
            end
        endcase
        if (cmd.e_shift)
        begin
            e_reg <= {1'b0, e_reg[31:1]};
        end
        if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        sel_re  = '0;
        sel_im  = '0;
        ext_cnt = '0;
        case (cmd.out_src)
            OS_ACC:   begin sel_re = acc_re_reg; sel_im = acc_im_reg; end
            OS_ADD:   begin sel_re = add_re;     sel_im = add_im;     end
            OS_SUB:   begin sel_re = sub_re;     sel_im = sub_im;     end
            OS_COUNT: ext_cnt = OW'(cnt_reg);
            default:
            begin
            end
        endcase
        ext_re = SW'(sel_re);
        ext_im = SW'(sel_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_re_reg  <= ext_re[7:0];
            out_im_reg  <= ext_im[7:0];
            out_ord_reg <= ext_cnt[14:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_re     = out_re_reg;
    assign result_im     = out_im_reg;
    assign element_order = out_ord_reg;

    assign stat.op           = op_reg;
    assign stat.lanes_done   = &ldone;
    assign stat.e_zero       = (e_reg == '0);
    assign stat.e_lsb        = e_reg[0];
    assign stat.a_zero       = (a_re_reg == '0) && (a_im_reg == '0);
    assign stat.acc_one      = (acc_re_reg == ONE) && (acc_im_reg == '0);
    assign stat.cnt_at_limit = (cnt_reg >= ORD_LIMIT);
    assign stat.slot_free    = !out_valid_reg || out_ready;

endmodule

>>> rtl/core/gfpsq_ctrl.sv
// Controller: sequences load, multiply, power and order steps for one word.
module gfpsq_ctrl
    import gfpsq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_LATCH   = 12'b000000000010,
        S_LOAD    = 12'b000000000100,
        S_DISP    = 12'b000000001000,
        S_MUL     = 12'b000000010000,
        S_POW_CHK = 12'b000000100000,
        S_POW_MUL = 12'b000001000000,
        S_POW_SQ  = 12'b000010000000,
        S_DIV_FIN = 12'b000100000000,
        S_ORD_CHK = 12'b001000000000,
        S_ORD_MUL = 12'b010000000000,
        S_FIN     = 12'b100000000000
    } state_t;

    state_t   state_reg, state_next;
    out_src_t src_reg, src_next;

    always_comb
    begin
        state_next    = state_reg;
        src_next      = src_reg;
        cmd           = '0;
        cmd.mul_sel   = MS_LOAD;
        cmd.wb        = WB_NONE;
        cmd.init      = INIT_NONE;
        cmd.out_src   = src_reg;
        in_ready      = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LATCH;
                end
            end
            S_LATCH:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_LOAD;
                state_next    = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.lanes_done)
                begin
                    cmd.wb     = WB_AB;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.op)
                    OP_ADD:
                    begin
                        src_next = OS_ADD; state_next = S_FIN;
                    end
                    OP_SUB:
                    begin
                        src_next = OS_SUB; state_next = S_FIN;
                    end
                    OP_MUL:
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = MS_A_B;
                        state_next    = S_MUL;
                    end
                    OP_DIV:
                    begin
                        cmd.init = INIT_POW_B; state_next = S_POW_CHK;
                    end
                    OP_POW:
                    begin
                        cmd.init = INIT_POW_A; state_next = S_POW_CHK;
                    end
                    OP_ORD:
                    begin
                        if (stat.a_zero)
                        begin
                            src_next = OS_ZERO; state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.init = INIT_ORD; state_next = S_ORD_CHK;
                        end
                    end
                    default:
                    begin
                        src_next = OS_ZERO; state_next = S_FIN;
                    end
                endcase
            end
            S_MUL:
            begin
                if (stat.lanes_done)
                begin
                    cmd.wb     = WB_ACC;
                    src_next   = OS_ACC;
                    state_next = S_FIN;
                end
            end
            S_POW_CHK:
            begin
                cmd.mul_start = 1'b1;
                if (stat.e_zero)
                begin
                    if (stat.op == OP_DIV)
                    begin
                        cmd.mul_sel = MS_A_ACC;
                        state_next  = S_DIV_FIN;
                    end
                    else
                    begin
                        cmd.mul_start = 1'b0;
                        src_next      = OS_ACC;
                        state_next    = S_FIN;
                    end
                end
                else if (stat.e_lsb)
                begin
                    cmd.mul_sel = MS_ACC_SQ;
                    state_next  = S_POW_MUL;
                end
                else
                begin
                    cmd.mul_sel = MS_SQ_SQ;
                    state_next  = S_POW_SQ;
                end
            end
            S_POW_MUL:
            begin
                cmd.mul_sel = MS_ACC_SQ;
                if (stat.lanes_done)
                begin
                    cmd.wb        = WB_ACC;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_SQ_SQ;
                    state_next    = S_POW_SQ;
                end
            end
            S_POW_SQ:
            begin
                cmd.mul_sel = MS_SQ_SQ;
                if (stat.lanes_done)
                begin
                    cmd.wb      = WB_SQ;
                    cmd.e_shift = 1'b1;
                    state_next  = S_POW_CHK;
                end
            end
            S_DIV_FIN:
            begin
                cmd.mul_sel = MS_A_ACC;
                if (stat.lanes_done)
                begin
                    cmd.wb     = WB_ACC;
                    src_next   = OS_ACC;
                    state_next = S_FIN;
                end
            end
            S_ORD_CHK:
            begin
                if (stat.acc_one)
                begin
                    src_next = OS_COUNT; state_next = S_FIN;
                end
                else if (stat.cnt_at_limit)
                begin
                    src_next = OS_ZERO; state_next = S_FIN;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_A_ACC;
                    state_next    = S_ORD_MUL;
                end
            end
            S_ORD_MUL:
            begin
                cmd.mul_sel = MS_A_ACC;
                if (stat.lanes_done)
                begin
                    cmd.wb      = WB_ACC;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_ORD_CHK;
                end
            end
            S_FIN:
            begin
                if (stat.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            src_reg   <= OS_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

    // lanes finish only while a multiply is awaited
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.lanes_done |-> (state_reg == S_LOAD || state_reg == S_MUL ||
            state_reg == S_POW_MUL || state_reg == S_POW_SQ ||
            state_reg == S_DIV_FIN || state_reg == S_ORD_MUL))
        else $error("lane done outside a wait state");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.slot_free)
        else $error("output word overwritten");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (state_reg == S_IDLE))
        else $error("no return to idle after result");

    a_no_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_FIN) |-> !cmd.mul_start)
        else $error("multiply started with no word in work");

endmodule

>>> rtl/core/gf_p_squared_arithmetic_unit.sv
// Top level of the GF(p^2) arithmetic unit: controller plus datapath.
//
// Computes add, subtract, multiply, divide, power and multiplicative order on
// elements re + im*x of GF(p^2) with x*x = -1 (PRIME must be a prime that is
// 3 mod 4). Operand parts are reduced modulo PRIME on entry. One word in gives
// one word out. Every field multiply runs on four bit-serial modular
// multiplier lanes in parallel. Add and subtract need only the entry reduction
// and the output. Divide raises the divisor to PRIME*PRIME-2 (zero divisor
// gives zero), then multiplies. Order repeats a multiply by the element until
// it reaches one, counting up to order PRIME*PRIME-1; zero has order 0.
// Words are handled one at a time; in_ready is high only while idle. A
// finished word waits in the output register, and the next input word is
// taken while it waits. Undefined operation codes give all-zero results.
module gf_p_squared_arithmetic_unit
    import gfpsq_pkg::*;
#(
    parameter int PRIME = DEF_PRIME
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [7:0]  first_re,
    input  logic [7:0]  first_im,
    input  logic [7:0]  second_re,
    input  logic [7:0]  second_im,
    input  logic [31:0] exponent,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  result_re,
    output logic [7:0]  result_im,
    output logic [14:0] element_order
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    gfpsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gfpsq_datapath #(.PRIME(PRIME)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .first_re      (first_re),
        .first_im      (first_im),
        .second_re     (second_re),
        .second_im     (second_im),
        .exponent      (exponent),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_re     (result_re),
        .result_im     (result_im),
        .element_order (element_order)
    );

endmodule

>>> tb/sv/gf_p_squared_arithmetic_unit_tb.sv
// Self-checking testbench for the GF(p^2) arithmetic unit: directed and random words.
`timescale 1ns / 1ps

module gf_p_squared_arithmetic_unit_tb;
    import gfpsq_pkg::*;

    localparam int P        = DEF_PRIME;
    localparam int N_RANDOM = 1880;

    // An element re + im*x with x*x = -1, parts kept reduced mod P.
    typedef struct {
        int unsigned re;
        int unsigned im;
    } gf_elem_t;

    // Expected result word.
    typedef struct {
        logic [7:0]  re;
        logic [7:0]  im;
        logic [14:0] ord;
    } gf_result_t;

    // Field arithmetic and the queue of pending results.
    class gf_scoreboard;
        gf_result_t pending[$];
        int         errors;
        int         checked;

        function gf_elem_t mk(int unsigned re, int unsigned im);
            gf_elem_t e;
            e.re = re % P;
            e.im = im % P;
            return e;
        endfunction

        function gf_elem_t fmul(gf_elem_t u, gf_elem_t v);
            int unsigned ac, bd, ad;
            ac = (u.re * v.re) % P;
            bd = (u.im * v.im) % P;
            ad = (u.im * v.re + u.re * v.im) % P;
            return mk(ac + P - bd, ad);
        endfunction

        // Right-to-left square and multiply.
        function gf_elem_t fpow(gf_elem_t b, logic [31:0] n);
            gf_elem_t acc, sq;
            acc = mk(1, 0);
            sq  = b;
            while (n != 0)
            begin
                if (n[0])
                    acc = fmul(acc, sq);
                sq = fmul(sq, sq);
                n  = n >> 1;
            end
            return acc;
        endfunction

        // Repeated multiply until 1; zero gives 0, a runaway search gives 0.
        function int unsigned forder(gf_elem_t u);
            gf_elem_t    r;
            int unsigned cnt;
            if (u.re == 0 && u.im == 0)
                return 0;
            r   = u;
            cnt = 1;
            while (!(r.re == 1 && r.im == 0))
            begin
                if (cnt >= P * P - 1)
                    return 0;
                r   = fmul(r, u);
                cnt = cnt + 1;
            end
            return cnt;
        endfunction

        function void note_input(logic [2:0] op, logic [7:0] fr, logic [7:0] fi,
                                 logic [7:0] sr, logic [7:0] si, logic [31:0] ex);
            gf_elem_t    a, b, r;
            int unsigned ord;
            gf_result_t  exp_w;
            a   = mk(32'(fr), 32'(fi));
            b   = mk(32'(sr), 32'(si));
            r   = mk(0, 0);
            ord = 0;
            case (op)
                OP_ADD: r = mk(a.re + b.re, a.im + b.im);
                OP_SUB: r = mk(a.re + P - b.re, a.im + P - b.im);
                OP_MUL: r = fmul(a, b);
                OP_DIV: r = fmul(a, fpow(b, 32'(P * P - 2)));
                OP_POW: r = fpow(a, ex);
                OP_ORD: ord = forder(a);
                default: ;
            endcase
            exp_w.re  = r.re[7:0];
            exp_w.im  = r.im[7:0];
            exp_w.ord = ord[14:0];
            pending = {pending, exp_w};
        endfunction

        function void check_result(logic [7:0] re, logic [7:0] im, logic [14:0] ord);
            gf_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word re=%0d im=%0d order=%0d",
                         $time, re, im, ord);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (re !== e.re)
            begin
                $display("%0t: result_re expected %0d actual %0d", $time, e.re, re);
                errors++;
            end
            if (im !== e.im)
            begin
                $display("%0t: result_im expected %0d actual %0d", $time, e.im, im);
                errors++;
            end
            if (ord !== e.ord)
            begin
                $display("%0t: element_order expected %0d actual %0d", $time, e.ord, ord);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [7:0]  first_re;
    logic [7:0]  first_im;
    logic [7:0]  second_re;
    logic [7:0]  second_im;
    logic [31:0] exponent;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  result_re;
    logic [7:0]  result_im;
    logic [14:0] element_order;

    gf_scoreboard sb;
    int           words_sent;
    int           phase;        // 0: sender 26 / receiver 63, 1: swapped, 2: no idling
    bit           stim_done;
    bit           hold_done;

    gf_p_squared_arithmetic_unit #(.PRIME(P)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .first_re(first_re),
        .first_im(first_im),
        .second_re(second_re),
        .second_im(second_im),
        .exponent(exponent),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_re(result_re),
        .result_im(result_im),
        .element_order(element_order)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Offer one word at the falling edge, hold it until the rising edge that
    // takes it, then log it with the scoreboard. Idle gaps come first.
    task automatic send_word(logic [2:0] op, logic [7:0] fr, logic [7:0] fi,
                             logic [7:0] sr, logic [7:0] si, logic [31:0] ex);
        int gap_pct;
        gap_pct = (phase == 0) ? 26 : (phase == 1) ? 63 : 0;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        operation = op;
        first_re  = fr;
        first_im  = fi;
        second_re = sr;
        second_im = si;
        exponent  = ex;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(op, fr, fi, sr, si, ex);
        words_sent++;
    endtask

    // Operand part: mostly reduced, sometimes above P to exercise entry reduction.
    function automatic logic [7:0] rand_part();
        if ($urandom_range(99) < 85)
            return 8'($urandom_range(P - 1));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random();
        int          pick;
        logic [2:0]  op;
        logic [7:0]  fr, fi, sr, si;
        logic [31:0] ex;
        pick = $urandom_range(99);
        fr   = rand_part();
        fi   = rand_part();
        sr   = rand_part();
        si   = rand_part();
        ex   = $urandom();
        if ($urandom_range(3) == 0)
            ex = $urandom_range(20);
        if ($urandom_range(19) == 0)
        begin
            sr = 8'd0;
            si = 8'd0;
        end
        if (pick < 16)      op = OP_ADD;
        else if (pick < 32) op = OP_SUB;
        else if (pick < 50) op = OP_MUL;
        else if (pick < 70) op = OP_DIV;
        else if (pick < 94) op = OP_POW;
        else if (pick < 97)
        begin
            // order search is slow on generic elements: keep to the prime
            // subfield or pure imaginary values, whose orders stay small
            op = OP_ORD;
            case ($urandom_range(2))
                0: fi = 8'd0;
                1: fr = 8'd0;
                default: fr = P[7:0] * 8'($urandom_range(1));
            endcase
        end
        else op = 3'($urandom_range(6, 7));
        send_word(op, fr, fi, sr, si, ex);
    endtask

    // Stimulus
    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_ADD;
        first_re   = '0;
        first_im   = '0;
        second_re  = '0;
        second_im  = '0;
        exponent   = '0;
        words_sent = 0;
        phase      = 0;
        stim_done  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, every opcode, special cases
        send_word(OP_ADD, 8'd0,   8'd0,   8'd0,   8'd0,   32'd0);
        send_word(OP_ADD, 8'd138, 8'd138, 8'd138, 8'd138, 32'd0);
        send_word(OP_SUB, 8'd0,   8'd0,   8'd138, 8'd138, 32'd0);
        send_word(OP_SUB, 8'd255, 8'd139, 8'd0,   8'd255, 32'hFFFF_FFFF);
        send_word(OP_MUL, 8'd0,   8'd1,   8'd0,   8'd1,   32'd0);   // x*x = -1
        send_word(OP_MUL, 8'd255, 8'd255, 8'd200, 8'd139, 32'd0);   // unreduced parts
        send_word(OP_MUL, 8'd138, 8'd138, 8'd138, 8'd138, 32'd0);
        send_word(OP_DIV, 8'd17,  8'd99,  8'd0,   8'd0,   32'd0);   // zero divisor
        send_word(OP_DIV, 8'd17,  8'd99,  8'd139, 8'd139, 32'd0);   // divisor reduces to zero
        send_word(OP_DIV, 8'd5,   8'd7,   8'd3,   8'd11,  32'd0);
        send_word(OP_DIV, 8'd1,   8'd0,   8'd0,   8'd1,   32'd0);
        send_word(OP_POW, 8'd0,   8'd0,   8'd0,   8'd0,   32'd0);   // zero to the zero
        send_word(OP_POW, 8'd23,  8'd45,  8'd0,   8'd0,   32'd0);
        send_word(OP_POW, 8'd23,  8'd45,  8'd0,   8'd0,   32'hFFFF_FFFF);
        send_word(OP_POW, 8'd0,   8'd0,   8'd0,   8'd0,   32'h8000_0000);
        send_word(OP_POW, 8'd200, 8'd77,  8'd0,   8'd0,   32'd1);
        send_word(OP_ORD, 8'd0,   8'd0,   8'd0,   8'd0,   32'd0);   // zero element
        send_word(OP_ORD, 8'd139, 8'd0,   8'd0,   8'd0,   32'd0);   // zero after reduction
        send_word(OP_ORD, 8'd1,   8'd0,   8'd0,   8'd0,   32'd0);
        send_word(OP_ORD, 8'd138, 8'd0,   8'd0,   8'd0,   32'd0);
        send_word(OP_ORD, 8'd0,   8'd1,   8'd0,   8'd0,   32'd0);
        send_word(OP_ORD, 8'd1,   8'd2,   8'd0,   8'd0,   32'd0);   // likely full order
        send_word(3'd6,   8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_word(3'd7,   8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            phase = (i < N_RANDOM / 3) ? 0 : (i < 2 * N_RANDOM / 3) ? 1 : 2;
            send_random();
        end
        @(negedge clk);
        in_valid  = 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: ready chosen at the falling edge, result taken at the rising
    // edge. Once, early in the no-idle phase, it holds off for a long stretch
    // so the block backs up and stalls its input.
    initial
    begin
        int hold_left;
        int stall_pct;
        out_ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && phase == 2)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            stall_pct = (phase == 0) ? 63 : (phase == 1) ? 26 : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
                out_ready = ($urandom_range(99) >= stall_pct);
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(result_re, result_im, element_order);
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
        $display("Sent %0d words over all opcodes incl. undefined ones; checked %0d results,",
                 words_sent, sb.checked);
        $display("with idle gaps on both sides and one long receiver hold-off.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("gf_p_squared_arithmetic_unit_tb: done, clean");
        else
            $display("gf_p_squared_arithmetic_unit_tb: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200ms;
        $display("Timeout with %0d results still expected", sb.pending.size());
        $display("gf_p_squared_arithmetic_unit_tb: done, errors");
        $finish;
    end

endmodule
